[rtl/lhst_pkg.sv]
// Shared types, codes and constants of the link health score tracker.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lhst_pkg;

	localparam int MAX_PEERS = 16;
	localparam int PEER_W    = 4;
	localparam int PIDX_W    = $clog2(MAX_PEERS);
	localparam int SCORE_W   = 17;
	localparam int UNITS_W   = 16;
	localparam int WORD_W    = 32;
	localparam int RANK_W    = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int DCNT_W    = 5;

	localparam logic [SCORE_W-1:0] ONE_Q16 = 17'h10000;

	localparam logic [1:0] OP_LIVE  = 2'd0;
	localparam logic [1:0] OP_DEAD  = 2'd1;
	localparam logic [1:0] OP_EPOCH = 2'd2;

	localparam logic [1:0] ST_APPLIED    = 2'd0;
	localparam logic [1:0] ST_DROPPED    = 2'd1;
	localparam logic [1:0] ST_NOT_RAISED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_OWN_RANK      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HL_UNITS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERSIST_EVERY = 2'd2;

	localparam logic [RANK_W-1:0]    RANK_RESET      = 5'h1F;
	localparam logic [UNITS_W-1:0]   HL_UNITS_RESET  = 16'd256;
	localparam logic [UNITS_W-1:0]   PERSIST_RESET   = 16'd16;

	localparam logic [DCNT_W-1:0] ALPHA_LAST = 5'd15;
	localparam logic [DCNT_W-1:0] MOD_LAST   = 5'd31;

	typedef enum logic [2:0] {
		K_LIVE,
		K_DEAD,
		K_EPOCH,
		K_BAD,
		K_DROP_RANGE,
		K_DROP_OWN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [PEER_W-1:0]   peer;
		logic [UNITS_W-1:0]  units;
		logic [WORD_W-1:0]   new_epoch;
	} cmd_t;

	typedef struct packed {
		logic                start;
		logic [SCORE_W-1:0]  rem_init;
		logic [WORD_W-1:0]   dividend;
		logic [SCORE_W-1:0]  divisor;
		logic [DCNT_W-1:0]   last;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [UNITS_W-1:0]  quotient;
		logic [SCORE_W-1:0]  remainder;
	} div_rsp_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SYNC,
		B_DIV,
		B_MUL,
		B_ANS,
		B_FIN
	} back_state_t;

endpackage

`default_nettype wire

[rtl/link_health_score_tracker.sv]
// Top level of the link health score tracker: configuration registers and
// the front queue, shared divider and back end. Depends on lhst_pkg,
// lhst_front, lhst_div and lhst_back.
// A report whose weight does not saturate waits for the 16 steps of the radix-2 weight
// divider; a report whose weight saturates and every other item skip the divider.
// The back end works on one item at a time; a two-entry queue takes items meanwhile.
// After a write of a nonzero persist_every, a remainder pass holds the back end.
// Reset is asynchronous, active low: scores go to 1.0, flags, version and epoch to zero.
`timescale 1ns / 1ps
`default_nettype none

module link_health_score_tracker import lhst_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [1:0]            opcode,
	input  wire logic [PEER_W-1:0]     peer,
	input  wire logic [UNITS_W-1:0]    units,
	input  wire logic [WORD_W-1:0]     new_epoch,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [1:0]                 status,
	output logic [SCORE_W-1:0]         score,
	output logic                       peer_live,
	output logic [WORD_W-1:0]          version_now,
	output logic [WORD_W-1:0]          epoch_now,
	output logic                       persist_request,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DAT_W-1:0]  cfg_data
);

	logic [RANK_W-1:0]  own_rank_q;
	logic [UNITS_W-1:0] hl_units_q, persist_every_q;
	logic               cfg_wr, pe_written, q_valid, q_pop;
	cmd_t               q_cmd;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign pe_written = cfg_wr && (cfg_index == CFG_PERSIST_EVERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_rank_q      <= RANK_RESET;
			hl_units_q      <= HL_UNITS_RESET;
			persist_every_q <= PERSIST_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_OWN_RANK:      own_rank_q      <= cfg_data[RANK_W-1:0];
				CFG_HL_UNITS:      hl_units_q      <= cfg_data;
				CFG_PERSIST_EVERY: persist_every_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lhst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.peer      (peer),
		.units     (units),
		.new_epoch (new_epoch),
		.own_rank  (own_rank_q),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop)
	);

	lhst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lhst_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_cmd           (q_cmd),
		.q_pop           (q_pop),
		.own_rank        (own_rank_q),
		.hl_units        (hl_units_q),
		.persist_every   (persist_every_q),
		.pe_written      (pe_written),
		.div_req         (div_req),
		.div_rsp         (div_rsp),
		.pop             (pop),
		.empty           (empty),
		.status          (status),
		.score           (score),
		.peer_live       (peer_live),
		.version_now     (version_now),
		.epoch_now       (epoch_now),
		.persist_request (persist_request)
	);

endmodule

`default_nettype wire

[rtl/lhst_front.sv]
// Front end: accepts items, classifies them and holds them in a short queue.
// Depends on lhst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lhst_front import lhst_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [1:0]           opcode,
	input  wire logic [PEER_W-1:0]    peer,
	input  wire logic [UNITS_W-1:0]   units,
	input  wire logic [WORD_W-1:0]    new_epoch,
	input  wire logic [RANK_W-1:0]    own_rank,
	output logic                      q_valid,
	output cmd_t                      q_cmd,
	input  wire logic                 q_pop
);

	cmd_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	cmd_t              cls;
	logic              acc;

	assign full    = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign acc     = push && !full;
	assign q_valid = (cnt_q != '0);
	assign q_cmd   = ent_q[rd_ptr_q];

	always_comb begin
		cls.peer      = peer;
		cls.units     = units;
		cls.new_epoch = new_epoch;
		case (opcode)
			OP_LIVE, OP_DEAD: begin
				if ({1'b0, peer} >= (PEER_W+1)'(MAX_PEERS)) begin
					cls.kind = K_DROP_RANGE;
				end else if (!own_rank[RANK_W-1] && (own_rank[PEER_W-1:0] == peer)) begin
					cls.kind = K_DROP_OWN;
				end else begin
					cls.kind = (opcode == OP_LIVE) ? K_LIVE : K_DEAD;
				end
			end
			OP_EPOCH: cls.kind = K_EPOCH;
			default:  cls.kind = K_BAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (acc) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({acc, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

endmodule

`default_nettype wire

[rtl/lhst_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, shared by the weight
// and persist remainder computations. Depends on lhst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lhst_div import lhst_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire div_req_t req,
	output div_rsp_t  rsp
);

	logic                busy_q, done_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic [SCORE_W-1:0]  rem_q, div_q;
	logic [WORD_W-1:0]   dvd_q;
	logic [UNITS_W-1:0]  quo_q;
	logic [SCORE_W:0]    trial, diff;
	logic                ge;

	always_comb begin
		trial = {rem_q, dvd_q[WORD_W-1]};
		diff  = trial - {1'b0, div_q};
		ge    = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.last;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SCORE_W-1:0] : trial[SCORE_W-1:0];
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			quo_q <= {quo_q[UNITS_W-2:0], ge};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

[rtl/lhst_back.sv]
// Back end: score table, version and epoch state, score update and result
// register. Depends on lhst_pkg and drives the shared lhst_div unit.
`timescale 1ns / 1ps
`default_nettype none

module lhst_back import lhst_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	input  wire cmd_t                 q_cmd,
	output logic                      q_pop,
	input  wire logic [RANK_W-1:0]    own_rank,
	input  wire logic [UNITS_W-1:0]   hl_units,
	input  wire logic [UNITS_W-1:0]   persist_every,
	input  wire logic                 pe_written,
	output div_req_t                  div_req,
	input  wire div_rsp_t             div_rsp,
	input  wire logic                 pop,
	output logic                      empty,
	output logic [1:0]                status,
	output logic [SCORE_W-1:0]        score,
	output logic                      peer_live,
	output logic [WORD_W-1:0]         version_now,
	output logic [WORD_W-1:0]         epoch_now,
	output logic                      persist_request
);

	back_state_t         state_q, state_d;
	cmd_t                cmd_q;
	logic [SCORE_W-1:0]  score_tab_q [MAX_PEERS];
	logic [MAX_PEERS-1:0] live_tab_q;
	logic [WORD_W-1:0]   version_q, epoch_q;
	logic [UNITS_W-1:0]  rem_q;
	logic                dirty_q;
	logic [SCORE_W-1:0]  alpha_q, keep_q;
	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [SCORE_W-1:0]  score_q;
	logic                live_q;
	logic [WORD_W-1:0]   version_out_q, epoch_out_q;
	logic                persist_q;

	logic                out_free, own_valid, sat, q_report, raise;
	logic [PIDX_W-1:0]   idx;
	logic [SCORE_W-1:0]  cur_score, inv_alpha, new_score;
	logic [2*SCORE_W-1:0] prod;
	logic [SCORE_W:0]    sum;
	logic [SCORE_W-1:0]  rem_inc;
	logic [UNITS_W-1:0]  rem_next;
	logic [WORD_W-1:0]   ver_next;
	logic                persist_hit;

	logic                out_load;
	logic [1:0]          o_status;
	logic [SCORE_W-1:0]  o_score;
	logic                o_live;
	logic [WORD_W-1:0]   o_version, o_epoch;
	logic                o_persist;

	always_comb begin
		out_free  = !out_valid_q || pop;
		own_valid = !own_rank[RANK_W-1];
		q_report  = (q_cmd.kind == K_LIVE) || (q_cmd.kind == K_DEAD);
		sat       = (hl_units == '0) || ({1'b0, q_cmd.units} >= {hl_units, 1'b0});
		raise     = (cmd_q.new_epoch > epoch_q) && own_valid;
		idx       = PIDX_W'(cmd_q.peer);
		cur_score = score_tab_q[idx];
		inv_alpha = ONE_Q16 - alpha_q;
		prod      = cur_score * inv_alpha;
		sum       = {1'b0, keep_q} + {1'b0, alpha_q};
		if (cmd_q.kind == K_LIVE) begin
			new_score = (sum > {1'b0, ONE_Q16}) ? ONE_Q16 : sum[SCORE_W-1:0];
		end else begin
			new_score = (keep_q >= alpha_q) ? keep_q - alpha_q : '0;
		end
		rem_inc  = {1'b0, rem_q} + 1'b1;
		rem_next = ((version_q == '1) || (rem_inc == {1'b0, persist_every})) ?
			'0 : rem_inc[UNITS_W-1:0];
		ver_next    = own_valid ? version_q + 1'b1 : version_q;
		persist_hit = own_valid && (persist_every != '0) && (rem_next == '0);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (dirty_q) begin
					if (persist_every != '0) begin
						state_d = B_SYNC;
					end
				end else if (q_valid && out_free) begin
					if (q_report) begin
						state_d = sat ? B_MUL : B_DIV;
					end else begin
						state_d = B_ANS;
					end
				end
			end
			B_SYNC: if (div_rsp.done) state_d = B_IDLE;
			B_DIV:  if (div_rsp.done) state_d = B_MUL;
			B_MUL:  state_d = B_FIN;
			B_FIN:  state_d = B_IDLE;
			B_ANS:  state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop            = 1'b0;
		div_req.start    = 1'b0;
		div_req.rem_init = '0;
		div_req.dividend = version_q;
		div_req.divisor  = {1'b0, persist_every};
		div_req.last     = MOD_LAST;
		out_load         = 1'b0;
		o_status         = ST_APPLIED;
		o_score          = '0;
		o_live           = 1'b0;
		o_version        = version_q;
		o_epoch          = epoch_q;
		o_persist        = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (dirty_q) begin
					div_req.start = (persist_every != '0);
				end else if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (q_report && !sat) begin
						div_req.start    = 1'b1;
						div_req.rem_init = {1'b0, q_cmd.units};
						div_req.dividend = '0;
						div_req.divisor  = {hl_units, 1'b0};
						div_req.last     = ALPHA_LAST;
					end
				end
			end
			B_ANS: begin
				out_load = 1'b1;
				case (cmd_q.kind)
					K_EPOCH: begin
						o_status = raise ? ST_APPLIED : ST_NOT_RAISED;
						if (raise) begin
							o_version = '0;
							o_epoch   = cmd_q.new_epoch;
						end
					end
					K_DROP_OWN: begin
						o_status = ST_DROPPED;
						o_score  = cur_score;
						o_live   = live_tab_q[idx];
					end
					K_DROP_RANGE: o_status = ST_DROPPED;
					default:      o_status = ST_NOT_RAISED;
				endcase
			end
			B_FIN: begin
				out_load  = 1'b1;
				o_score   = new_score;
				o_live    = (cmd_q.kind == K_LIVE);
				o_version = ver_next;
				o_persist = persist_hit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			dirty_q     <= 1'b0;
			out_valid_q <= 1'b0;
			live_tab_q  <= '0;
			version_q   <= '0;
			epoch_q     <= '0;
			rem_q       <= '0;
			for (int i = 0; i < MAX_PEERS; i++) begin
				score_tab_q[i] <= ONE_Q16;
			end
		end else begin
			state_q <= state_d;
			if (pe_written) begin
				dirty_q <= 1'b1;
			end else if (state_q == B_IDLE && dirty_q && persist_every == '0) begin
				dirty_q <= 1'b0;
			end else if (state_q == B_SYNC && div_rsp.done) begin
				dirty_q <= 1'b0;
			end
			if (state_q == B_SYNC && div_rsp.done) begin
				rem_q <= div_rsp.remainder[UNITS_W-1:0];
			end
			if (state_q == B_FIN) begin
				score_tab_q[idx] <= new_score;
				live_tab_q[idx]  <= (cmd_q.kind == K_LIVE);
				if (own_valid) begin
					version_q <= ver_next;
					rem_q     <= rem_next;
				end
			end
			if (state_q == B_ANS && cmd_q.kind == K_EPOCH && raise) begin
				version_q <= '0;
				rem_q     <= '0;
				epoch_q   <= cmd_q.new_epoch;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q   <= q_cmd;
			alpha_q <= ONE_Q16;
		end else if (state_q == B_DIV && div_rsp.done) begin
			alpha_q <= {1'b0, div_rsp.quotient};
		end
		if (state_q == B_MUL) begin
			keep_q <= prod[SCORE_W+15:16];
		end
		if (out_load) begin
			status_q      <= o_status;
			score_q       <= o_score;
			live_q        <= o_live;
			version_out_q <= o_version;
			epoch_out_q   <= o_epoch;
			persist_q     <= o_persist;
		end
	end

	assign empty           = !out_valid_q;
	assign status          = status_q;
	assign score           = score_q;
	assign peer_live       = live_q;
	assign version_now     = version_out_q;
	assign epoch_now       = epoch_out_q;
	assign persist_request = persist_q;

endmodule

`default_nettype wire
